/* rtl/humidity_pressure_temp_compensation_top_assert.svh */
// Assertion macros for the compensation block.
// Used by humidity_pressure_temp_compensation_top; no other dependencies.
`ifndef HUMIDITY_PRESSURE_TEMP_COMPENSATION_TOP_ASSERT_SVH
`define HUMIDITY_PRESSURE_TEMP_COMPENSATION_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// clocked check, idle during reset
`define HPTC_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition in one cycle implies a consequence in the next
`define HPTC_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);
`else
`define HPTC_CHECK(lbl, prop, msg)
`define HPTC_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/hptc_pkg.sv */
// Shared types and constants of the compensation block.
// No dependencies; used by the divider and the top level.
package hptc_pkg;

	localparam int DIV_W  = 64;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 64;

	// register indexes
	localparam logic [CFG_AW-1:0] CFG_TEMP   = 3'd0;
	localparam logic [CFG_AW-1:0] CFG_PLOW   = 3'd1;
	localparam logic [CFG_AW-1:0] CFG_PHIGH  = 3'd2;
	localparam logic [CFG_AW-1:0] CFG_PNINE  = 3'd3;
	localparam logic [CFG_AW-1:0] CFG_HUM_A  = 3'd4;
	localparam logic [CFG_AW-1:0] CFG_HUM_B  = 3'd5;

	localparam logic [32:0] TF_PRESS_OFS = 33'd128000;
	localparam logic [31:0] TF_HUM_OFS   = 32'd76800;
	localparam logic [63:0] PRESS_FULL   = 64'd1048576;
	localparam logic [63:0] PRESS_SCALE  = 64'd3125;
	localparam logic [63:0] PRESS_BIAS   = 64'h0000_8000_0000_0000;
	localparam logic [31:0] HUM_RND      = 32'd16384;
	localparam logic [31:0] HUM_Y_OFS    = 32'd2097152;
	localparam logic [31:0] HUM_I2_OFS   = 32'd32768;
	localparam logic [31:0] HUM_Y_RND    = 32'd8192;
	localparam logic [31:0] HUM_MAX      = 32'd419430400;

	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [19:0] raw_pressure;
		logic [15:0] raw_humidity;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] temperature_centi;
		logic [31:0]        pressure_q24_8;
		logic               pressure_invalid;
		logic [16:0]        humidity_q22_10;
	} result_t;

endpackage

/* rtl/humidity_pressure_temp_compensation_top.sv */
// One word per cycle while the result word is not held.
// Depth is set by the pressure divider plus the multiply stages around it.
// A stalled result holds the whole pipeline; nothing is lost or repeated.
// arst_n clears valid bits and calibration registers; datapath registers are not reset.
`include "humidity_pressure_temp_compensation_top_assert.svh"

module humidity_pressure_temp_compensation_top import hptc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  sample_t           sample,
	output logic              result_valid,
	input  logic              result_ready,
	output result_t           result,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_data
);

	typedef struct packed {
		logic [31:0] tc;
		logic        bad;
		logic [16:0] hum;
	} side_t;

	// calibration registers
	logic [47:0] temp_q;
	logic [63:0] plow_q, phigh_q;
	logic [15:0] pnine_q;
	logic [39:0] huma_q;
	logic [23:0] humb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q  <= '0;
			plow_q  <= '0;
			phigh_q <= '0;
			pnine_q <= '0;
			huma_q  <= '0;
			humb_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_TEMP:  temp_q  <= cfg_data[47:0];
				CFG_PLOW:  plow_q  <= cfg_data;
				CFG_PHIGH: phigh_q <= cfg_data;
				CFG_PNINE: pnine_q <= cfg_data[15:0];
				CFG_HUM_A: huma_q  <= cfg_data[39:0];
				CFG_HUM_B: humb_q  <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// coefficient fields
	logic [15:0] t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
	logic [7:0] h1, h3;
	logic signed [7:0] h6;
	logic signed [11:0] h4, h5;

	assign t1 = temp_q[15:0];
	assign t2 = temp_q[31:16];
	assign t3 = temp_q[47:32];
	assign p1 = plow_q[15:0];
	assign p2 = plow_q[31:16];
	assign p3 = plow_q[47:32];
	assign p4 = plow_q[63:48];
	assign p5 = phigh_q[15:0];
	assign p6 = phigh_q[31:16];
	assign p7 = phigh_q[47:32];
	assign p8 = phigh_q[63:48];
	assign p9 = pnine_q;
	assign h1 = huma_q[7:0];
	assign h2 = huma_q[23:8];
	assign h3 = huma_q[31:24];
	assign h6 = huma_q[39:32];
	assign h4 = humb_q[11:0];
	assign h5 = humb_q[23:12];

	// global advance: the pipeline moves unless the result word is held
	logic en;
	logic res_vld_q;
	result_t res_q;
	assign en = !res_vld_q || result_ready;
	assign sample_ready = en;

	// pipeline registers
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic v_s13, v_s14, v_s15, v_s16, div_vld;
	sample_t smp_s1;
	logic [19:0] rp_s2, rp_s3, rp_s4, rp_s5, rp_s6, rp_s7, rp_s8, rp_s9, rp_s10;
	logic [15:0] rh_s2, rh_s3, rh_s4, rh_s5, rh_s6;
	logic [31:0] a_s2, b_s2, m1_s3, bb_s3, v1_s4, m2_s4, tf_s5, hv_s6;
	logic [31:0] tc_s6, tc_s7, tc_s8, tc_s9, tc_s10, tc_s11, tc_s12;
	logic signed [32:0] w1_s6;
	logic [63:0] sq_s7, a6_s8, a3_s8;
	logic signed [48:0] m5_s7, m2p_s7, m5_s8, m2p_s8;
	logic [63:0] w2_s9, w1b_s9, mp_s10, w2_s10, w1c_s11, num0_s11, num_s12, den_s12;
	logic bad_s11, bad_s12;
	logic [31:0] hx0_s7, i1m_s7, i2m_s7, hx_s8, y0_s8, hx_s9, ym_s9, hv_s10;
	logic [31:0] hv_s11, ss_s11, hv_s12, ht_s12;
	logic [63:0] pr_s13, q_s13, r9_s13, r8_s13, pr_s14, r8_s14, ll_s14;
	logic [31:0] lh_s14, hl_s14;
	logic [63:0] pr_s15, r8_s15, prod_s15, sum_s16;
	side_t sd_s13, sd_s14, sd_s15, sd_s16;

	// temperature combinational terms
	logic signed [47:0] m1f, m2f;
	logic signed [31:0] bs;
	logic [31:0] tc5, tfv;
	assign m1f = $signed(a_s2) * t2;
	assign bs  = $signed(bb_s3) >>> 12;
	assign m2f = bs * t3;
	assign tfv = v1_s4 + 32'($signed(m2_s4) >>> 14);
	assign tc5 = (tf_s5 << 2) + tf_s5 + 32'd128;

	// pressure combinational terms
	logic signed [65:0] sqf;
	logic signed [63:0] a6f, a3f;
	logic [63:0] mpf, w1c;
	assign sqf = w1_s6 * w1_s6;
	assign a6f = $signed(sq_s7) * p6;
	assign a3f = $signed(sq_s7) * p3;
	assign mpf = (w1b_s9 + PRESS_BIAS) * {48'd0, p1};
	assign w1c = 64'($signed(mp_s10) >>> 33);

	// humidity combinational terms
	logic signed [43:0] h5f;
	logic signed [39:0] h6f;
	logic signed [47:0] h2f;
	logic [31:0] i1, i2, y1, yv, hs, vv, vcl;
	assign h5f = h5 * $signed(hv_s6);
	assign h6f = $signed(hv_s6) * h6;
	assign i1  = 32'($signed(i1m_s7) >>> 10);
	assign i2  = 32'($signed(i2m_s7) >>> 11) + HUM_I2_OFS;
	assign y1  = 32'($signed(y0_s8) >>> 10) + HUM_Y_OFS;
	assign h2f = $signed(y1) * h2;
	assign yv  = 32'($signed(ym_s9 + HUM_Y_RND) >>> 14);
	assign hs  = 32'($signed(hv_s10) >>> 15);
	assign vv  = hv_s12 - 32'($signed(ht_s12) >>> 4);
	always_comb begin
		if (vv[31]) begin
			vcl = '0;
		end else if (vv > HUM_MAX) begin
			vcl = HUM_MAX;
		end else begin
			vcl = vv;
		end
	end

	// divider
	side_t sd_in, sd_out;
	logic [63:0] quo;
	assign sd_in = '{tc: tc_s12, bad: bad_s12, hum: vcl[28:12]};

	hptc_div #(.W(DIV_W), .SW($bits(side_t))) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (v_s12),
		.num    (num_s12),
		.den    (den_s12),
		.side_i (sd_in),
		.vld_o  (div_vld),
		.quo    (quo),
		.side_o (sd_out)
	);

	// post-division terms
	logic signed [63:0] qv, r9f, r8f;
	logic [63:0] pr_out;
	assign qv  = $signed(quo) >>> 13;
	assign r9f = p9 * qv;
	assign r8f = p8 * $signed(quo);
	assign pr_out = 64'($signed(sum_s16) >>> 8) + (64'(p7) << 4);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
			{v_s9, v_s10, v_s11, v_s12, v_s13, v_s14, v_s15, v_s16} <= '0;
			res_vld_q <= 1'b0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <=
				{sample_valid, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7};
			{v_s9, v_s10, v_s11, v_s12} <= {v_s8, v_s9, v_s10, v_s11};
			{v_s13, v_s14, v_s15, v_s16} <= {div_vld, v_s13, v_s14, v_s15};
			res_vld_q <= v_s16;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (en) begin
			smp_s1 <= sample;
			// temperature
			a_s2  <= {15'd0, smp_s1.raw_temperature[19:3]} - {15'd0, t1, 1'b0};
			b_s2  <= {16'd0, smp_s1.raw_temperature[19:4]} - {16'd0, t1};
			rp_s2 <= smp_s1.raw_pressure;
			rh_s2 <= smp_s1.raw_humidity;
			m1_s3 <= m1f[31:0];
			bb_s3 <= b_s2 * b_s2;
			rp_s3 <= rp_s2;
			rh_s3 <= rh_s2;
			v1_s4 <= 32'($signed(m1_s3) >>> 11);
			m2_s4 <= m2f[31:0];
			rp_s4 <= rp_s3;
			rh_s4 <= rh_s3;
			tf_s5 <= tfv;
			rp_s5 <= rp_s4;
			rh_s5 <= rh_s4;
			tc_s6 <= 32'($signed(tc5) >>> 8);
			w1_s6 <= $signed({tf_s5[31], tf_s5}) - $signed(TF_PRESS_OFS);
			hv_s6 <= tf_s5 - TF_HUM_OFS;
			rp_s6 <= rp_s5;
			rh_s6 <= rh_s5;
			// pressure ahead of the divider
			sq_s7  <= sqf[63:0];
			m5_s7  <= w1_s6 * p5;
			m2p_s7 <= w1_s6 * p2;
			a6_s8  <= a6f;
			a3_s8  <= a3f;
			m5_s8  <= m5_s7;
			m2p_s8 <= m2p_s7;
			w2_s9  <= a6_s8 + (64'(m5_s8) << 17) + (64'(p4) << 35);
			w1b_s9 <= 64'($signed(a3_s8) >>> 8) + (64'(m2p_s8) << 12);
			mp_s10 <= mpf;
			w2_s10 <= w2_s9;
			w1c_s11  <= w1c;
			bad_s11  <= (w1c == '0);
			num0_s11 <= ((PRESS_FULL - {44'd0, rp_s10}) << 31) - w2_s10;
			num_s12  <= num0_s11 * PRESS_SCALE;
			den_s12  <= w1c_s11;
			bad_s12  <= bad_s11;
			{rp_s7, rp_s8, rp_s9, rp_s10} <= {rp_s6, rp_s7, rp_s8, rp_s9};
			{tc_s7, tc_s8, tc_s9} <= {tc_s6, tc_s7, tc_s8};
			{tc_s10, tc_s11, tc_s12} <= {tc_s9, tc_s10, tc_s11};
			// humidity
			hx0_s7 <= {2'd0, rh_s6, 14'd0} - (32'(h4) << 20) - h5f[31:0] + HUM_RND;
			i1m_s7 <= h6f[31:0];
			i2m_s7 <= hv_s6 * {24'd0, h3};
			hx_s8  <= 32'($signed(hx0_s7) >>> 15);
			y0_s8  <= i1 * i2;
			hx_s9  <= hx_s8;
			ym_s9  <= h2f[31:0];
			hv_s10 <= hx_s9 * yv;
			hv_s11 <= hv_s10;
			ss_s11 <= hs * hs;
			hv_s12 <= hv_s11;
			ht_s12 <= 32'($signed(ss_s11) >>> 7) * {24'd0, h1};
			// pressure after the divider
			pr_s13 <= quo;
			q_s13  <= qv;
			r9_s13 <= r9f;
			r8_s13 <= r8f;
			sd_s13 <= sd_out;
			ll_s14 <= {32'd0, r9_s13[31:0]} * {32'd0, q_s13[31:0]};
			lh_s14 <= r9_s13[31:0] * q_s13[63:32];
			hl_s14 <= r9_s13[63:32] * q_s13[31:0];
			pr_s14 <= pr_s13;
			r8_s14 <= r8_s13;
			sd_s14 <= sd_s13;
			prod_s15 <= ll_s14 + {lh_s14 + hl_s14, 32'd0};
			pr_s15   <= pr_s14;
			r8_s15   <= r8_s14;
			sd_s15   <= sd_s14;
			sum_s16 <= pr_s15 + 64'($signed(prod_s15) >>> 25)
				+ 64'($signed(r8_s15) >>> 19);
			sd_s16  <= sd_s15;
			// result word
			res_q.temperature_centi <= sd_s16.tc;
			res_q.pressure_q24_8    <= sd_s16.bad ? 32'd0 : pr_out[31:0];
			res_q.pressure_invalid  <= sd_s16.bad;
			res_q.humidity_q22_10   <= sd_s16.hum;
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

	// checks
	`HPTC_CHECK(a_inv_zero, result_valid && result.pressure_invalid |-> result.pressure_q24_8 == 32'd0, "invalid pressure not zero")
	`HPTC_CHECK(a_hum_max, result_valid |-> result.humidity_q22_10 <= 17'd102400, "humidity above clamp")
	`HPTC_NEXT(a_hold, result_valid && !result_ready, $stable(v_s16) && $stable(sd_s16), "pipeline moved while held")

endmodule

/* rtl/hptc_div.sv */
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
// Depends on hptc_pkg; instantiated by the top level.
module hptc_div import hptc_pkg::*; #(
	parameter int W  = DIV_W,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  logic [W-1:0]  num,
	input  logic [W-1:0]  den,
	input  logic [SW-1:0] side_i,
	output logic          vld_o,
	output logic [W-1:0]  quo,
	output logic [SW-1:0] side_o
);

	logic [W-1:0]  rem_s [W];
	logic [W-1:0]  nq_s  [W+2];
	logic [W-1:0]  dvs_s [W];
	logic          neg_s [W+1];
	logic [SW-1:0] sd_s  [W+2];
	logic [W+1:0]  vld_s;

	// valid bits move with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[W:0], vld_i};
		end
	end

	// operand magnitudes and result sign
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= '0;
			nq_s[0]  <= num[W-1] ? (~num + 1'b1) : num;
			dvs_s[0] <= den[W-1] ? (~den + 1'b1) : den;
			neg_s[0] <= num[W-1] ^ den[W-1];
			sd_s[0]  <= side_i;
		end
	end

	// restoring steps
	for (genvar k = 1; k <= W; k++) begin : g_step
		logic [W-1:0] part;
		logic [W:0]   diff;
		logic         qbit;
		assign part = {rem_s[k-1][W-2:0], nq_s[k-1][W-1]};
		assign diff = {1'b0, part} - {1'b0, dvs_s[k-1]};
		assign qbit = ~diff[W];
		always_ff @(posedge clk) begin
			if (en) begin
				nq_s[k]  <= {nq_s[k-1][W-2:0], qbit};
				neg_s[k] <= neg_s[k-1];
				sd_s[k]  <= sd_s[k-1];
			end
		end
		if (k < W) begin : g_keep
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= qbit ? diff[W-1:0] : part;
					dvs_s[k] <= dvs_s[k-1];
				end
			end
		end
	end

	// sign fix
	always_ff @(posedge clk) begin
		if (en) begin
			nq_s[W+1] <= neg_s[W] ? (~nq_s[W] + 1'b1) : nq_s[W];
			sd_s[W+1] <= sd_s[W];
		end
	end

	assign vld_o  = vld_s[W+1];
	assign quo    = nq_s[W+1];
	assign side_o = sd_s[W+1];

endmodule
